@@ rtl/dbd_pkg.sv @@
// Shared types, register indexes and helpers for the detection box decoder.
// No dependencies; every module of the block imports this package.
`default_nettype none

package dbd_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   localparam logic [CSR_INDEX_W-1:0] CSR_SCORE_THRESHOLD = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLASS_COUNT     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_INVERSE_SCALE   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAD_LEFT        = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAD_TOP         = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH     = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT    = 3'd6;

   localparam logic [13:0] IMAGE_MAX = 14'd8192;

   // Effective configuration: class count and image limits already clipped.
   typedef struct packed {
      logic [15:0] score_threshold;
      logic [7:0]  class_count;
      logic [23:0] inverse_scale;
      logic [9:0]  pad_left;
      logic [9:0]  pad_top;
      logic [13:0] image_width;
      logic [13:0] image_height;
   } cfg_type;

   // One detection waiting for box decode.
   typedef struct packed {
      logic [6:0]  best_class;
      logic [15:0] best_score;
      logic [13:0] anchor_index;
      logic [15:0] center_x;
      logic [15:0] center_y;
      logic [15:0] box_width;
      logic [15:0] box_height;
   } det_type;

   function automatic logic [13:0] image_limit(input logic [13:0] r);
      logic [13:0] lim;
      if (r == 14'd0) begin
         lim = 14'd1;
      end else if (r > IMAGE_MAX) begin
         lim = IMAGE_MAX;
      end else begin
         lim = r;
      end
      return lim;
   endfunction

endpackage

`default_nettype wire

@@ rtl/dbd_req_if.sv @@
// Input channel of the detection box decoder: one class score word per anchor class.
// No dependencies.
`default_nettype none

interface dbd_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] center_x;
   logic [15:0] center_y;
   logic [15:0] box_width;
   logic [15:0] box_height;
   logic [15:0] class_score;

   modport source (output valid, center_x, center_y, box_width, box_height, class_score,
                   input ready);
   modport sink   (input valid, center_x, center_y, box_width, box_height, class_score,
                   output ready);
endinterface

`default_nettype wire

@@ rtl/dbd_rsp_if.sv @@
// Result channel of the detection box decoder: one detection word per passing anchor.
// No dependencies.
`default_nettype none

interface dbd_rsp_if;
   logic        valid;
   logic        ready;
   logic [6:0]  best_class;
   logic [15:0] best_score_out;
   logic [12:0] box_left;
   logic [12:0] box_top;
   logic [13:0] box_w_out;
   logic [13:0] box_h_out;
   logic [13:0] anchor_index;

   modport source (output valid, best_class, best_score_out, box_left, box_top, box_w_out,
                   box_h_out, anchor_index, input ready);
   modport sink   (input valid, best_class, best_score_out, box_left, box_top, box_w_out,
                   box_h_out, anchor_index, output ready);
endinterface

`default_nettype wire

@@ rtl/dbd_csr.sv @@
// Configuration registers of the detection box decoder, with range clipping.
// Depends on dbd_pkg.
`default_nettype none

module dbd_csr
   import dbd_pkg::*;
#(
   parameter int MAX_CLASSES = 128
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wr_data,
   output cfg_type                     cfg
);

   logic [15:0] threshold_ff;
   logic [7:0]  class_count_ff;
   logic [23:0] inverse_scale_ff;
   logic [9:0]  pad_left_ff;
   logic [9:0]  pad_top_ff;
   logic [13:0] image_width_ff;
   logic [13:0] image_height_ff;
   logic [7:0]  count_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff     <= 16'd16384;
         class_count_ff   <= 8'd80;
         inverse_scale_ff <= 24'd65536;
         pad_left_ff      <= 10'd0;
         pad_top_ff       <= 10'd0;
         image_width_ff   <= 14'd640;
         image_height_ff  <= 14'd640;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SCORE_THRESHOLD: threshold_ff     <= csr_wr_data[15:0];
            CSR_CLASS_COUNT:     class_count_ff   <= csr_wr_data[7:0];
            CSR_INVERSE_SCALE:   inverse_scale_ff <= csr_wr_data[23:0];
            CSR_PAD_LEFT:        pad_left_ff      <= csr_wr_data[9:0];
            CSR_PAD_TOP:         pad_top_ff       <= csr_wr_data[9:0];
            CSR_IMAGE_WIDTH:     image_width_ff   <= csr_wr_data[13:0];
            CSR_IMAGE_HEIGHT:    image_height_ff  <= csr_wr_data[13:0];
            default: ;
         endcase
      end
   end

   // Zero classes act as one; more than the build supports act as the maximum.
   always_comb begin
      if (class_count_ff == 8'd0) begin
         count_eff = 8'd1;
      end else if (class_count_ff > 8'(MAX_CLASSES)) begin
         count_eff = 8'(MAX_CLASSES);
      end else begin
         count_eff = class_count_ff;
      end
   end

   always_comb begin
      cfg.score_threshold = threshold_ff;
      cfg.class_count     = count_eff;
      cfg.inverse_scale   = inverse_scale_ff;
      cfg.pad_left        = pad_left_ff;
      cfg.pad_top         = pad_top_ff;
      cfg.image_width     = image_limit(image_width_ff);
      cfg.image_height    = image_limit(image_height_ff);
   end

endmodule

`default_nettype wire

@@ rtl/dbd_argmax.sv @@
// Running best-class tracker and anchor sequencer; holds one pending detection.
// Depends on dbd_pkg and dbd_req_if.
`default_nettype none

module dbd_argmax
   import dbd_pkg::*;
#(
   parameter int ANCHOR_COUNT = 8400
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   dbd_req_if.sink      req,
   input  wire logic    det_take,
   output logic         det_valid,
   output det_type      det
);

   logic [15:0] best_score_ff, best_score_in;
   logic [6:0]  best_class_ff, best_class_in;
   logic [6:0]  class_pos_ff, class_pos_in;
   logic [13:0] anchor_ff, anchor_in;
   logic        det_valid_ff, det_valid_in;
   det_type     det_ff, det_in;
   logic        accept;
   logic        take_score;
   logic        last_class;
   logic        emit;

   assign req.ready = !det_valid_ff || det_take;
   assign accept    = req.valid && req.ready;

   always_comb begin
      // First class always wins; later ones only when strictly greater.
      take_score = (class_pos_ff == 7'd0) || (req.class_score > best_score_ff);
      best_score_in = take_score ? req.class_score : best_score_ff;
      best_class_in = take_score ? class_pos_ff : best_class_ff;
      last_class = ({1'b0, class_pos_ff} + 8'd1) >= cfg.class_count;
      emit = last_class && (best_score_in >= cfg.score_threshold);

      class_pos_in = last_class ? 7'd0 : class_pos_ff + 7'd1;
      if (last_class) begin
         if (({1'b0, anchor_ff} + 15'd1) >= 15'(ANCHOR_COUNT)) begin
            anchor_in = 14'd0;
         end else begin
            anchor_in = anchor_ff + 14'd1;
         end
      end else begin
         anchor_in = anchor_ff;
      end

      det_in.best_class   = best_class_in;
      det_in.best_score   = best_score_in;
      det_in.anchor_index = anchor_ff;
      det_in.center_x     = req.center_x;
      det_in.center_y     = req.center_y;
      det_in.box_width    = req.box_width;
      det_in.box_height   = req.box_height;

      if (accept && emit) begin
         det_valid_in = 1'b1;
      end else if (det_take) begin
         det_valid_in = 1'b0;
      end else begin
         det_valid_in = det_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_score_ff <= 16'd0;
         best_class_ff <= 7'd0;
         class_pos_ff  <= 7'd0;
         anchor_ff     <= 14'd0;
         det_valid_ff  <= 1'b0;
      end else begin
         det_valid_ff <= det_valid_in;
         if (accept) begin
            best_score_ff <= best_score_in;
            best_class_ff <= best_class_in;
            class_pos_ff  <= class_pos_in;
            anchor_ff     <= anchor_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         det_ff <= det_in;
      end
   end

   assign det_valid = det_valid_ff;
   assign det       = det_ff;

endmodule

`default_nettype wire

@@ rtl/dbd_unletterbox.sv @@
// Box decode pipeline: multiply by inverse scale, center to corner, clamp to image.
// Depends on dbd_pkg and dbd_rsp_if.
`default_nettype none

module dbd_unletterbox
   import dbd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   input  wire logic    det_valid,
   input  wire det_type det,
   output logic         det_take,
   dbd_rsp_if.source    rsp
);

   // Scale stage
   logic               v2_ff;
   logic [6:0]         class2_ff;
   logic [15:0]        score2_ff;
   logic [13:0]        anchor2_ff;
   logic signed [42:0] ox_ff, oy_ff, ox_in, oy_in;
   logic [39:0]        wox_ff, woy_ff, wox_in, woy_in;
   logic signed [17:0] dx, dy;
   logic signed [24:0] inv_s;

   // Edge stage
   logic               v3_ff;
   logic [6:0]         class3_ff;
   logic [15:0]        score3_ff;
   logic [13:0]        anchor3_ff;
   logic [12:0]        left_ff, top_ff, left_in, top_in;
   logic [17:0]        sw_ff, sh_ff;

   // Output stage
   logic               v4_ff;
   logic [6:0]         class4_ff;
   logic [15:0]        score4_ff;
   logic [13:0]        anchor4_ff;
   logic [12:0]        left4_ff, top4_ff;
   logic [13:0]        w4_ff, h4_ff, w_in, h_in;

   logic adv2, adv3, adv4;

   // Edge in image pixels: negative clamps to zero, beyond the image to lim-1.
   function automatic logic [12:0] clamp_edge(input logic [42:0] o,
                                              input logic [39:0] wo,
                                              input logic [13:0] lim);
      logic signed [44:0] t;
      logic [20:0]        q;
      logic [12:0]        e;
      t = $signed({o[42], o, 1'b0}) - $signed({5'b0, wo});
      q = t[43:23];
      if (t[44]) begin
         e = 13'd0;
      end else if (q >= {7'b0, lim}) begin
         e = 13'(lim - 14'd1);
      end else begin
         e = q[12:0];
      end
      return e;
   endfunction

   function automatic logic [13:0] clip_size(input logic [17:0] s,
                                             input logic [12:0] e,
                                             input logic [13:0] lim);
      logic [13:0] avail;
      avail = lim - {1'b0, e};
      return (s > {4'b0, avail}) ? avail : s[13:0];
   endfunction

   assign adv4     = !v4_ff || rsp.ready;
   assign adv3     = !v3_ff || adv4;
   assign adv2     = !v2_ff || adv3;
   assign det_take = det_valid && adv2;

   always_comb begin
      dx     = $signed({2'b0, det.center_x}) - $signed({2'b0, cfg.pad_left, 6'b0});
      dy     = $signed({2'b0, det.center_y}) - $signed({2'b0, cfg.pad_top, 6'b0});
      inv_s  = $signed({1'b0, cfg.inverse_scale});
      ox_in  = 43'(dx) * 43'(inv_s);
      oy_in  = 43'(dy) * 43'(inv_s);
      wox_in = 40'(det.box_width) * 40'(cfg.inverse_scale);
      woy_in = 40'(det.box_height) * 40'(cfg.inverse_scale);
      left_in = clamp_edge(ox_ff, wox_ff, cfg.image_width);
      top_in  = clamp_edge(oy_ff, woy_ff, cfg.image_height);
      w_in    = clip_size(sw_ff, left_ff, cfg.image_width);
      h_in    = clip_size(sh_ff, top_ff, cfg.image_height);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (adv2) v2_ff <= det_valid;
         if (adv3) v3_ff <= v2_ff;
         if (adv4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (det_take) begin
         class2_ff  <= det.best_class;
         score2_ff  <= det.best_score;
         anchor2_ff <= det.anchor_index;
         ox_ff      <= ox_in;
         oy_ff      <= oy_in;
         wox_ff     <= wox_in;
         woy_ff     <= woy_in;
      end
      if (adv3 && v2_ff) begin
         class3_ff  <= class2_ff;
         score3_ff  <= score2_ff;
         anchor3_ff <= anchor2_ff;
         left_ff    <= left_in;
         top_ff     <= top_in;
         sw_ff      <= wox_ff[39:22];
         sh_ff      <= woy_ff[39:22];
      end
      if (adv4 && v3_ff) begin
         class4_ff  <= class3_ff;
         score4_ff  <= score3_ff;
         anchor4_ff <= anchor3_ff;
         left4_ff   <= left_ff;
         top4_ff    <= top_ff;
         w4_ff      <= w_in;
         h4_ff      <= h_in;
      end
   end

   assign rsp.valid          = v4_ff;
   assign rsp.best_class     = class4_ff;
   assign rsp.best_score_out = score4_ff;
   assign rsp.box_left       = left4_ff;
   assign rsp.box_top        = top4_ff;
   assign rsp.box_w_out      = w4_ff;
   assign rsp.box_h_out      = h4_ff;
   assign rsp.anchor_index   = anchor4_ff;

endmodule

`default_nettype wire

@@ rtl/detection_box_decoder.sv @@
// Detection box decoder top level: argmax over class scores and box unletterbox.
// Depends on dbd_pkg, dbd_req_if, dbd_rsp_if, dbd_csr, dbd_argmax, dbd_unletterbox.
//
// Usage:
//  req_chan carries one word per class score of the current anchor, in class
//  order, with the anchor's box fields (read on the last class word only).
//  rsp_chan carries one detection word per anchor whose best score reaches
//  the threshold; anchors below it produce nothing.
//  The csr_ port writes one register per cycle; write only while idle.
//  Throughput: one input word per cycle while req_chan ready is high. A
//  detection word passes the pending register, scale multiply, edge clamp
//  and output register in that order before it is valid on rsp_chan.
//  Reset clears the running best score, class and anchor counters, empties
//  the pipeline and loads the register defaults.
//  When rsp_chan stalls, the pipeline stages fill one by one; req_chan keeps
//  taking words until a detection has nowhere to go, then holds ready low.
`default_nettype none

module detection_box_decoder
   import dbd_pkg::*;
#(
   parameter int ANCHOR_COUNT = 8400,
   parameter int MAX_CLASSES  = 128
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wr_data,
   dbd_req_if.sink                     req_chan,
   dbd_rsp_if.source                   rsp_chan
);

   cfg_type cfg;
   det_type det;
   logic    det_valid;
   logic    det_take;

   // Register file; class count and image size come out already clipped.
   dbd_csr #(
      .MAX_CLASSES (MAX_CLASSES)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   // Running argmax; holds a detection until the decode pipeline takes it.
   dbd_argmax #(
      .ANCHOR_COUNT (ANCHOR_COUNT)
   ) u_argmax (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req       (req_chan),
      .det_take  (det_take),
      .det_valid (det_valid),
      .det       (det)
   );

   // Unletterbox and clamp; advance each stage when the next one frees up.
   dbd_unletterbox u_unletterbox (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .det_valid (det_valid),
      .det       (det),
      .det_take  (det_take),
      .rsp       (rsp_chan)
   );

endmodule

`default_nettype wire
